// ===== src/irtps_pkg.sv =====
// Shared types and constants for the IR timing to pulse symbol encoder.
package irtps_pkg;

	localparam int DUR_W   = 15;
	localparam int COUNT_W = 11;
	localparam int STAT_W  = 2;

	localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

	localparam logic [STAT_W-1:0] ST_SYMBOL    = 2'd0;
	localparam logic [STAT_W-1:0] ST_COUNT_ERR = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY_END = 2'd2;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = Q_PTR_W + 1;

	typedef struct packed {
		logic level;
		logic last;
		logic count_err;
	} tag_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

// ===== src/irtps_if.sv =====
// Stream interfaces for timing items and pulse symbol results.
interface irtps_in_if #(
	parameter int TIMING_WIDTH = 20
);
	logic                    valid;
	logic                    ready;
	logic [TIMING_WIDTH-1:0] timing_us;
	logic                    last_timing;

	modport source (output valid, output timing_us, output last_timing, input ready);
	modport sink   (input valid, input timing_us, input last_timing, output ready);
endinterface

interface irtps_out_if;
	logic                         valid;
	logic                         ready;
	logic [irtps_pkg::DUR_W-1:0]  first_duration;
	logic                         first_level;
	logic [irtps_pkg::DUR_W-1:0]  second_duration;
	logic                         second_level;
	logic [irtps_pkg::STAT_W-1:0] status;
	logic                         end_of_sequence;

	modport source (output valid, output first_duration, output first_level,
		output second_duration, output second_level, output status,
		output end_of_sequence, input ready);
	modport sink   (input valid, input first_duration, input first_level,
		input second_duration, input second_level, input status,
		input end_of_sequence, output ready);
endinterface

// ===== src/irtps_front.sv =====
// Front end: accept timings, track the count and level, classify count errors.
module irtps_front #(
	parameter int MAX_TIMINGS  = 1200,
	parameter int TIMING_WIDTH = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	irtps_in_if.sink                timings,
	input  logic                    cfg_we,
	input  logic                    cfg_wdata,
	input  irtps_pkg::qstat_t       q_stat,
	output logic                    push,
	output logic [TIMING_WIDTH-1:0] push_timing,
	output irtps_pkg::tag_t         push_tag,
	output logic [irtps_pkg::COUNT_W-1:0] count
);

	logic                          invert_q;
	logic [irtps_pkg::COUNT_W-1:0] count_q;

	assign timings.ready = !q_stat.full;
	assign push          = timings.valid && !q_stat.full;
	assign push_timing   = timings.timing_us;
	assign count         = count_q;

	always_comb begin
		push_tag.level     = invert_q ^ ~count_q[0];
		push_tag.last      = timings.last_timing;
		push_tag.count_err = timings.last_timing &&
			(count_q == '0 || count_q >= irtps_pkg::COUNT_W'(MAX_TIMINGS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (cfg_we) begin
				invert_q <= cfg_wdata;
			end
			if (push) begin
				if (timings.last_timing) begin
					count_q <= '0;
				end else if (count_q != irtps_pkg::COUNT_SAT) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== src/irtps_queue.sv =====
// Short FIFO between the front end and the back end.
module irtps_queue #(
	parameter int W = 23
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [W-1:0]      push_data,
	input  logic              pop,
	output logic [W-1:0]      head_data,
	output irtps_pkg::qstat_t stat
);

	logic [W-1:0]                  entry_q [irtps_pkg::Q_DEPTH];
	logic [irtps_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [irtps_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [irtps_pkg::Q_CNT_W-1:0] cnt_q;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == irtps_pkg::Q_CNT_W'(irtps_pkg::Q_DEPTH));
	assign head_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/irtps_back.sv =====
// Back end: cut timings into chunks, merge, pair into symbols, drive results.
module irtps_back #(
	parameter int MAX_CHUNK    = 32767,
	parameter int TIMING_WIDTH = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  irtps_pkg::qstat_t       q_stat,
	input  logic [TIMING_WIDTH-1:0] head_timing,
	input  irtps_pkg::tag_t         head_tag,
	output logic                    pop,
	irtps_out_if.source             symbols
);

	localparam int DW = irtps_pkg::DUR_W;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_ERR    = 2'd1;
	localparam logic [1:0] S_CHUNK  = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	localparam logic [DW-1:0]           CHUNK_MAX = DW'(MAX_CHUNK);
	localparam logic [TIMING_WIDTH-1:0] CHUNK_MAX_T = TIMING_WIDTH'(MAX_CHUNK);

	logic [1:0]              st_q;
	logic [TIMING_WIDTH-1:0] rem_q;
	logic                    lvl_q;
	logic                    last_q;
	logic                    pv_q;
	logic [DW-1:0]           pd_q;
	logic                    pl_q;
	logic                    hv_q;
	logic [DW-1:0]           hd_q;
	logic                    hl_q;
	logic                    ov_q;

	logic [DW-1:0]                 chunk;
	logic [DW:0]                   sum;
	logic                          merge;
	logic                          slot_free;
	logic                          emit;
	logic                          go;
	logic [DW-1:0]                 e_d0;
	logic                          e_l0;
	logic [DW-1:0]                 e_d1;
	logic                          e_l1;
	logic [irtps_pkg::STAT_W-1:0]  e_st;
	logic                          e_eos;
	logic [DW-1:0]                 fd_q;
	logic                          fl_q;
	logic [DW-1:0]                 sd_q;
	logic                          sl_q;
	logic [irtps_pkg::STAT_W-1:0]  stat_q;
	logic                          eos_q;

	assign chunk     = (rem_q < CHUNK_MAX_T) ? rem_q[DW-1:0] : CHUNK_MAX;
	assign sum       = {1'b0, pd_q} + {1'b0, chunk};
	assign merge     = pv_q && (pl_q == lvl_q) && (sum <= {1'b0, CHUNK_MAX});
	assign slot_free = !ov_q || symbols.ready;

	always_comb begin
		pop   = 1'b0;
		emit  = 1'b0;
		go    = 1'b0;
		e_d0  = '0;
		e_l0  = 1'b0;
		e_d1  = '0;
		e_l1  = 1'b0;
		e_st  = irtps_pkg::ST_SYMBOL;
		e_eos = 1'b0;
		case (st_q)
			S_IDLE: begin
				pop = !q_stat.empty;
			end
			S_ERR: begin
				emit  = 1'b1;
				e_st  = irtps_pkg::ST_COUNT_ERR;
				e_eos = 1'b1;
				go    = slot_free;
			end
			S_CHUNK: begin
				if (rem_q == '0 || merge) begin
					go = 1'b1;
				end else begin
					if (pv_q && hv_q) begin
						emit = 1'b1;
						e_d0 = hd_q;
						e_l0 = hl_q;
						e_d1 = pd_q;
						e_l1 = pl_q;
					end
					go = !emit || slot_free;
				end
			end
			S_FINISH: begin
				if (pv_q && hv_q) begin
					emit  = 1'b1;
					e_d0  = hd_q;
					e_l0  = hl_q;
					e_d1  = pd_q;
					e_l1  = pl_q;
					e_eos = 1'b1;
				end else if (hv_q && !pv_q) begin
					emit  = 1'b1;
					e_d0  = hd_q;
					e_l0  = hl_q;
					e_d1  = DW'(1);
					e_eos = 1'b1;
				end else if (!pv_q) begin
					emit  = 1'b1;
					e_st  = irtps_pkg::ST_EMPTY_END;
					e_eos = 1'b1;
				end
				go = !emit || slot_free;
			end
			default: begin
				go = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			pv_q <= 1'b0;
			hv_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (emit && go) begin
				ov_q <= 1'b1;
			end else if (symbols.ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (pop) begin
						st_q <= head_tag.count_err ? S_ERR : S_CHUNK;
					end
				end
				S_ERR: begin
					if (go) begin
						pv_q <= 1'b0;
						hv_q <= 1'b0;
						st_q <= S_IDLE;
					end
				end
				S_CHUNK: begin
					if (rem_q == '0) begin
						st_q <= last_q ? S_FINISH : S_IDLE;
					end else if (!merge && go) begin
						if (pv_q) begin
							hv_q <= !hv_q;
						end
						pv_q <= 1'b1;
					end
				end
				S_FINISH: begin
					if (go) begin
						if (pv_q && !hv_q) begin
							hv_q <= 1'b1;
							pv_q <= 1'b0;
						end else begin
							pv_q <= 1'b0;
							hv_q <= 1'b0;
							st_q <= S_IDLE;
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit && go) begin
			fd_q   <= e_d0;
			fl_q   <= e_l0;
			sd_q   <= e_d1;
			sl_q   <= e_l1;
			stat_q <= e_st;
			eos_q  <= e_eos;
		end
		case (st_q)
			S_IDLE: begin
				if (pop) begin
					rem_q  <= head_timing;
					lvl_q  <= head_tag.level;
					last_q <= head_tag.last;
				end
			end
			S_CHUNK: begin
				if (rem_q != '0) begin
					if (merge) begin
						pd_q  <= sum[DW-1:0];
						rem_q <= rem_q - TIMING_WIDTH'(chunk);
					end else if (go) begin
						if (pv_q && !hv_q) begin
							hd_q <= pd_q;
							hl_q <= pl_q;
						end
						pd_q  <= chunk;
						pl_q  <= lvl_q;
						rem_q <= rem_q - TIMING_WIDTH'(chunk);
					end
				end
			end
			S_FINISH: begin
				if (go && pv_q && !hv_q) begin
					hd_q <= pd_q;
					hl_q <= pl_q;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign symbols.valid           = ov_q;
	assign symbols.first_duration  = fd_q;
	assign symbols.first_level     = fl_q;
	assign symbols.second_duration = sd_q;
	assign symbols.second_level    = sl_q;
	assign symbols.status          = stat_q;
	assign symbols.end_of_sequence = eos_q;

endmodule

// ===== src/ir_timing_to_pulse_symbols.sv =====
// Top level of the IR timing to pulse symbol encoder.
//
// channel   dir  transfer on          payload
// timings   in   valid && ready       timing_us, last_timing
// symbols   out  valid && ready       first/second duration and level, status, eos
// cfg       in   cfg_we               cfg_wdata -> invert_levels
//
// The front end takes one timing per cycle into a four-entry queue while the queue is not full.
// The back end pulls an item, cuts it into chunks of at most MAX_CHUNK, closes
// the item and, on the last timing, flushes any held or pending duration.
// A result leaves through one output register; a full register that is not taken stalls the back end.
// Reset is asynchronous and clears the count, queue, pairing state and output valid.
module ir_timing_to_pulse_symbols #(
	parameter int MAX_TIMINGS  = 1200,
	parameter int MAX_CHUNK    = 32767,
	parameter int TIMING_WIDTH = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	irtps_in_if.sink    timings,
	irtps_out_if.source symbols,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	localparam int QW = TIMING_WIDTH + $bits(irtps_pkg::tag_t);

	irtps_pkg::qstat_t             q_stat;
	logic                          push;
	logic [TIMING_WIDTH-1:0]       push_timing;
	irtps_pkg::tag_t               push_tag;
	logic                          pop;
	logic [QW-1:0]                 head_data;
	logic [TIMING_WIDTH-1:0]       head_timing;
	irtps_pkg::tag_t               head_tag;
	logic [irtps_pkg::COUNT_W-1:0] count;

	assign head_timing = head_data[TIMING_WIDTH-1:0];
	assign head_tag    = head_data[QW-1:TIMING_WIDTH];

	irtps_front #(
		.MAX_TIMINGS  (MAX_TIMINGS),
		.TIMING_WIDTH (TIMING_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.timings     (timings),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.q_stat      (q_stat),
		.push        (push),
		.push_timing (push_timing),
		.push_tag    (push_tag),
		.count       (count)
	);

	irtps_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_tag, push_timing}),
		.pop       (pop),
		.head_data (head_data),
		.stat      (q_stat)
	);

	irtps_back #(
		.MAX_CHUNK    (MAX_CHUNK),
		.TIMING_WIDTH (TIMING_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.head_timing (head_timing),
		.head_tag    (head_tag),
		.pop         (pop),
		.symbols     (symbols)
	);

`ifndef SYNTH
	a_last_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(timings.valid && timings.ready && timings.last_timing) |=> (count == '0))
		else $error("count not cleared after final timing");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue read while empty");

	a_status_ends_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(symbols.valid && symbols.status != irtps_pkg::ST_SYMBOL)
			|-> symbols.end_of_sequence)
		else $error("error or empty result without end of sequence");
`endif

endmodule

// ===== test/ir_timing_to_pulse_symbols_tb.sv =====
// Self-checking testbench for the IR timing to pulse symbol encoder.
module ir_timing_to_pulse_symbols_tb;

	localparam int TIMING_W     = 20;
	localparam int MAX_TIMINGS  = 1200;
	localparam int MAX_CHUNK    = 32767;
	localparam int DRAIN_CYCLES = 64;
	localparam int LONG_HOLD    = 400;
	localparam int RANDOM_ITEMS = 190;

	typedef struct packed {
		logic [irtps_pkg::DUR_W-1:0]  first_dur;
		logic                         first_lvl;
		logic [irtps_pkg::DUR_W-1:0]  second_dur;
		logic                         second_lvl;
		logic [irtps_pkg::STAT_W-1:0] status;
		logic                         eos;
	} pulse_sym_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	irtps_in_if #(.TIMING_WIDTH(TIMING_W)) timing_ch ();
	irtps_out_if symbol_ch ();

	ir_timing_to_pulse_symbols #(
		.MAX_TIMINGS (MAX_TIMINGS),
		.MAX_CHUNK   (MAX_CHUNK),
		.TIMING_WIDTH(TIMING_W)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.timings   (timing_ch),
		.symbols   (symbol_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// encoder state mirror
	logic                          inv_lvl;
	logic [irtps_pkg::COUNT_W-1:0] seq_count;
	int                            pend_dur;
	logic                          pend_lvl;
	bit                            pend_ok;
	int                            held_dur;
	logic                          held_lvl;
	bit                            held_ok;

	pulse_sym_t symbols_expected[$];
	int         timing_list[$];

	int error_count;
	int items_sent;
	int sequences_sent;
	int symbols_checked;
	int burst_left;
	bit tx_no_gaps;
	bit long_stall_req;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic void clear_seq();
		seq_count = '0;
		pend_dur  = 0;
		pend_lvl  = 1'b0;
		pend_ok   = 1'b0;
		held_dur  = 0;
		held_lvl  = 1'b0;
		held_ok   = 1'b0;
	endfunction

	function automatic void push_symbol(input int fd, input logic fl, input int sd,
		input logic sl, input logic [irtps_pkg::STAT_W-1:0] st);
		pulse_sym_t s;
		s.first_dur  = fd[irtps_pkg::DUR_W-1:0];
		s.first_lvl  = fl;
		s.second_dur = sd[irtps_pkg::DUR_W-1:0];
		s.second_lvl = sl;
		s.status     = st;
		s.eos        = 1'b0;
		symbols_expected.insert(symbols_expected.size(), s);
	endfunction

	function automatic void mark_last_eos();
		pulse_sym_t tail;
		tail = symbols_expected[symbols_expected.size() - 1];
		tail.eos = 1'b1;
		symbols_expected[symbols_expected.size() - 1] = tail;
	endfunction

	function automatic void pair_dur(input int d, input logic l);
		if (held_ok) begin
			push_symbol(held_dur, held_lvl, d, l, irtps_pkg::ST_SYMBOL);
			held_ok  = 1'b0;
			held_dur = 0;
			held_lvl = 1'b0;
		end else begin
			held_dur = d;
			held_lvl = l;
			held_ok  = 1'b1;
		end
	endfunction

	function automatic void predict_timing(input logic [TIMING_W-1:0] t, input bit last);
		int         rem;
		int         chunk;
		int         total;
		int         n_before;
		logic       lvl;
		n_before = symbols_expected.size();
		total    = int'(seq_count) + 1;
		if (last && (total < 2 || total > MAX_TIMINGS)) begin
			push_symbol(0, 1'b0, 0, 1'b0, irtps_pkg::ST_COUNT_ERR);
			mark_last_eos();
			clear_seq();
			return;
		end
		lvl = seq_count[0] ? inv_lvl : ~inv_lvl;
		rem = int'(t);
		while (rem > 0) begin
			chunk = (rem < MAX_CHUNK) ? rem : MAX_CHUNK;
			if (pend_ok && pend_lvl == lvl && pend_dur + chunk <= MAX_CHUNK) begin
				pend_dur += chunk;
			end else begin
				if (pend_ok)
					pair_dur(pend_dur, pend_lvl);
				pend_dur = chunk;
				pend_lvl = lvl;
				pend_ok  = 1'b1;
			end
			rem -= chunk;
		end
		if (!last) begin
			if (seq_count != irtps_pkg::COUNT_SAT)
				seq_count++;
			return;
		end
		if (pend_ok)
			pair_dur(pend_dur, pend_lvl);
		if (held_ok)
			push_symbol(held_dur, held_lvl, 1, 1'b0, irtps_pkg::ST_SYMBOL);
		if (symbols_expected.size() == n_before)
			push_symbol(0, 1'b0, 0, 1'b0, irtps_pkg::ST_EMPTY_END);
		mark_last_eos();
		clear_seq();
	endfunction

	// result checker
	function automatic void check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		pulse_sym_t e;
		if (arst_n && symbol_ch.valid && symbol_ch.ready) begin
			if (symbols_expected.size() == 0) begin
				$display("%0t: unexpected symbol transfer, expected none actual %0h/%0h/%0d",
					$time, symbol_ch.first_duration, symbol_ch.second_duration,
					symbol_ch.status);
				error_count++;
			end else begin
				e = symbols_expected.pop_front();
				check_field("first_duration", 16'(e.first_dur),
					16'(symbol_ch.first_duration));
				check_field("first_level", 16'(e.first_lvl), 16'(symbol_ch.first_level));
				check_field("second_duration", 16'(e.second_dur),
					16'(symbol_ch.second_duration));
				check_field("second_level", 16'(e.second_lvl), 16'(symbol_ch.second_level));
				check_field("status", 16'(e.status), 16'(symbol_ch.status));
				check_field("end_of_sequence", 16'(e.eos), 16'(symbol_ch.end_of_sequence));
				symbols_checked++;
			end
		end
	end

	// receiver: own stall pattern plus long hold-off on request
	initial begin
		int   hold_left;
		int   rx_mode;
		int   mode_left;
		int   phase;
		logic rdy;
		logic [7:0] stall_mask;
		hold_left  = 0;
		rx_mode    = 0;
		mode_left  = 0;
		phase      = 0;
		stall_mask = 8'hff;
		symbol_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				hold_left = LONG_HOLD;
				long_stall_req <= 1'b0;
			end
			if (mode_left == 0) begin
				rx_mode    = $urandom_range(0, 3);
				mode_left  = $urandom_range(20, 120);
				stall_mask = 8'($urandom_range(1, 255));
			end
			mode_left--;
			phase = (phase + 1) % 8;
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (rx_mode)
					0: rdy = 1'b1;
					1: rdy = ($urandom_range(0, 3) != 0);
					2: rdy = stall_mask[phase];
					default: rdy = 1'($urandom_range(0, 1));
				endcase
			end
			symbol_ch.ready <= rdy;
		end
	end

	// sender: one transfer, with burst and gap shaping
	task automatic send_timing(input logic [TIMING_W-1:0] t, input bit last);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(30, 60);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 16);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			end
			if (tx_no_gaps)
				gap = 0;
			if (gap > 0) begin
				timing_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		timing_ch.valid       <= 1'b1;
		timing_ch.timing_us   <= t;
		timing_ch.last_timing <= last;
		do @(posedge clk); while (!timing_ch.ready);
		predict_timing(t, last);
		items_sent++;
		if (last)
			sequences_sent++;
	endtask

	task automatic send_list();
		for (int i = 0; i < timing_list.size(); i++)
			send_timing(TIMING_W'(timing_list[i]), i == timing_list.size() - 1);
		timing_list.delete();
	endtask

	task automatic wait_idle();
		timing_ch.valid <= 1'b0;
		while (symbols_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_invert(input logic v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		inv_lvl = v;
	endtask

	function automatic logic [TIMING_W-1:0] rand_timing();
		case ($urandom_range(0, 19))
			0, 1:    return '0;
			2:       return '1;
			3:       return TIMING_W'(MAX_CHUNK + $urandom_range(0, 1));
			4:       return TIMING_W'($urandom_range(MAX_CHUNK - 300, MAX_CHUNK));
			5, 6:    return TIMING_W'($urandom());
			7, 8, 9: return TIMING_W'($urandom_range(1, 300));
			default: return TIMING_W'($urandom_range(300, 20000));
		endcase
	endfunction

	task automatic test_basic();
		timing_list = '{9000, 4500, 560, 1690, 560};
		send_list();
		wait_idle();
	endtask

	task automatic test_extremes();
		timing_list = '{(1 << TIMING_W) - 1, 0, (1 << TIMING_W) - 1, 1};
		send_list();
		timing_list = '{MAX_CHUNK, MAX_CHUNK + 1};
		send_list();
		wait_idle();
	endtask

	task automatic test_zero_merge();
		timing_list = '{100, 0, 200, 40000, 0, 100};
		send_list();
		wait_idle();
	endtask

	task automatic test_short_and_empty();
		timing_list = '{500};
		send_list();
		timing_list = '{0, 0};
		send_list();
		wait_idle();
	endtask

	task automatic test_invert();
		set_invert(1'b1);
		timing_list = '{9000, 4500, 560, 1690, 560};
		send_list();
		wait_idle();
		set_invert(1'b0);
	endtask

	task automatic send_long(input int n);
		for (int i = 0; i < n; i++)
			send_timing(TIMING_W'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 2000) : 0),
				i == n - 1);
	endtask

	task automatic test_count_limits();
		tx_no_gaps = 1'b1;
		send_long(1);
		send_long(2);
		send_long(1);
		wait_idle();
		set_invert(1'b1);
		send_long(3);
		send_long(1);
		wait_idle();
		set_invert(1'b0);
		tx_no_gaps = 1'b0;
	endtask

	task automatic test_backpressure();
		long_stall_req <= 1'b1;
		for (int s = 0; s < 5; s++) begin
			for (int i = 0; i < 6; i++)
				timing_list.insert(timing_list.size(), int'($urandom_range(1, 70000)));
			send_list();
		end
		wait_idle();
	endtask

	task automatic test_random();
		int count;
		int kind;
		int len;
		count = 0;
		while (count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 5) == 0) begin
				wait_idle();
				set_invert(1'($urandom_range(0, 1)));
			end
			kind = $urandom_range(0, 19);
			if (kind == 0)
				len = 1;
			else if (kind == 1)
				len = $urandom_range(13, 40);
			else
				len = $urandom_range(2, 12);
			for (int i = 0; i < len; i++)
				send_timing((kind == 2) ? '0 : rand_timing(), i == len - 1);
			count += len;
		end
		wait_idle();
	endtask

	initial begin
		error_count     = 0;
		items_sent      = 0;
		sequences_sent  = 0;
		symbols_checked = 0;
		burst_left      = 0;
		tx_no_gaps      = 1'b0;
		long_stall_req  = 1'b0;
		inv_lvl         = 1'b0;
		clear_seq();
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = 1'b0;
		timing_ch.valid       = 1'b0;
		timing_ch.timing_us   = '0;
		timing_ch.last_timing = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_invert(1'b0);
		test_basic();
		test_extremes();
		test_zero_merge();
		test_short_and_empty();
		test_invert();
		test_count_limits();
		test_backpressure();
		test_random();
		wait_idle();
		$display("covered %0d sequences, %0d timings, %0d symbols checked", sequences_sent,
			items_sent, symbols_checked);
		$display("both polarities, chunk splits, zero merges, short count errors, long output stall");
		if (error_count == 0) begin
			$display("ir_timing_to_pulse_symbols_tb passed");
		end else begin
			$display("ir_timing_to_pulse_symbols_tb failed");
		end
		$finish;
	end

	initial begin
		#6000000;
		$display("ir_timing_to_pulse_symbols_tb failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/irtps_pkg.sv
src/irtps_if.sv
src/irtps_front.sv
src/irtps_queue.sv
src/irtps_back.sv
src/ir_timing_to_pulse_symbols.sv
test/ir_timing_to_pulse_symbols_tb.sv
